// ----- sv/apf_pkg.sv -----
// Shared types and constants for the articulation point finder.
// No dependencies.
package apf_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int NW = VW + 1;
    localparam int CW = 7;
    localparam int TW = 7;

    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_FIND  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]    action;
        logic [VW-1:0] vertex_a;
        logic [VW-1:0] vertex_b;
    } apf_in_t;

    typedef struct packed {
        logic                    status;
        logic [MAX_VERTICES-1:0] cut_mask;
    } apf_out_t;

endpackage

// ----- sv/articulation_point_finder.sv -----
// Articulation point finder top level: adjacency memory and DFS sequencer.
// Depends on apf_pkg.
//
// One word in, one word out. A find runs a DFS that scans each vertex's adjacency row
// one neighbor at a time; each tree edge adds a return from the child and each other
// edge a check at either end. Output stalls add to the time of any action. A new word
// is taken once the previous result has been delivered. vertex_count may be written at
// any time the block is idle; counts outside 1..64 are clamped.
module articulation_point_finder
    import apf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  apf_in_t  in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output apf_out_t out_data,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  logic [CW-1:0] cfg_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EA   = 4'd1;
    localparam logic [3:0] S_EB   = 4'd2;
    localparam logic [3:0] S_OUT  = 4'd3;
    localparam logic [3:0] S_ROOT = 4'd4;
    localparam logic [3:0] S_ROW  = 4'd5;
    localparam logic [3:0] S_SCAN = 4'd6;
    localparam logic [3:0] S_DISC = 4'd7;
    localparam logic [3:0] S_POP1 = 4'd8;
    localparam logic [3:0] S_POP2 = 4'd9;

    localparam logic [NW-1:0] N_MAX = NW'(MAX_VERTICES);

    logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
    logic [TW-1:0]           disc_mem [MAX_VERTICES];
    logic [TW-1:0]           low_mem [MAX_VERTICES];
    logic [VW-1:0]           par_mem [MAX_VERTICES];
    logic [VW+NW-1:0]        stack_mem [MAX_VERTICES];

    logic                    adj_we, disc_we, low_we, par_we, stk_we;
    logic [VW-1:0]           adj_waddr, disc_waddr, low_waddr, par_waddr, stk_waddr;
    logic [MAX_VERTICES-1:0] adj_wdata;
    logic [TW-1:0]           disc_wdata, low_wdata;
    logic [VW-1:0]           par_wdata;
    logic [VW+NW-1:0]        stk_wdata;
    logic [VW-1:0]           adj_raddr, disc_raddr, low_raddr, par_raddr, stk_raddr;
    logic [MAX_VERTICES-1:0] adj_rdata_reg;
    logic                    adj_rvalid_reg;
    logic [TW-1:0]           disc_rdata_reg, low_rdata_reg;
    logic [VW-1:0]           par_rdata_reg;
    logic [VW+NW-1:0]        stk_rdata_reg;

    logic [3:0]              state_reg, state_next;
    logic [CW-1:0]           count_reg;
    logic [MAX_VERTICES-1:0] row_valid_reg, row_valid_next;
    logic [MAX_VERTICES-1:0] visited_reg, visited_next;
    logic [MAX_VERTICES-1:0] cut_reg, cut_next;
    logic [MAX_VERTICES-1:0] row_reg, row_next;
    logic [VW-1:0]           a_reg, a_next, b_reg, b_next;
    logic [VW-1:0]           u_reg, u_next, par_u_reg, par_u_next;
    logic [NW-1:0]           nxt_reg, nxt_next, r_reg, r_next, sp_reg, sp_next;
    logic [TW-1:0]           time_reg, time_next, low_u_reg, low_u_next;
    logic [TW-1:0]           low_c_reg, low_c_next;
    logic [CW-1:0]           rc_reg, rc_next;
    logic                    ov_reg, ov_next;
    apf_out_t                od_reg, od_next;

    logic [NW-1:0]           n_eff;
    logic [VW-1:0]           nv, pp;
    logic [NW-1:0]           sp_m1, sp_m2;
    logic [TW-1:0]           t_inc, lp;
    logic [MAX_VERTICES-1:0] rd_row;

    always_comb
    begin
        if (count_reg == '0)
            n_eff = NW'(1);
        else if (count_reg > CW'(N_MAX))
            n_eff = N_MAX;
        else
            n_eff = NW'(count_reg);
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ov_reg;
    assign out_data  = od_reg;
    assign cfg_ready = 1'b1;

    assign nv     = nxt_reg[VW-1:0];
    assign pp     = stk_rdata_reg[VW-1:0];
    assign sp_m1  = sp_reg - NW'(1);
    assign sp_m2  = sp_reg - NW'(2);
    assign t_inc  = time_reg + TW'(1);
    assign rd_row = adj_rvalid_reg ? adj_rdata_reg : '0;
    assign lp     = (low_c_reg < low_rdata_reg) ? low_c_reg : low_rdata_reg;

    always_comb
    begin
        state_next     = state_reg;
        row_valid_next = row_valid_reg;
        visited_next   = visited_reg;
        cut_next       = cut_reg;
        row_next       = row_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        u_next         = u_reg;
        par_u_next     = par_u_reg;
        nxt_next       = nxt_reg;
        r_next         = r_reg;
        sp_next        = sp_reg;
        time_next      = time_reg;
        low_u_next     = low_u_reg;
        low_c_next     = low_c_reg;
        rc_next        = rc_reg;
        ov_next        = ov_reg;
        od_next        = od_reg;
        adj_we = 1'b0; adj_waddr = a_reg; adj_wdata = '0; adj_raddr = a_reg;
        disc_we = 1'b0; disc_waddr = u_reg; disc_wdata = t_inc; disc_raddr = nv;
        low_we = 1'b0; low_waddr = u_reg; low_wdata = low_u_reg; low_raddr = pp;
        par_we = 1'b0; par_waddr = u_reg; par_wdata = u_reg; par_raddr = pp;
        stk_we = 1'b0; stk_waddr = sp_m1[VW-1:0]; stk_wdata = '0;
        stk_raddr = sp_m2[VW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    a_next = in_data.vertex_a;
                    b_next = in_data.vertex_b;
                    od_next = '0;
                    unique case (in_data.action)
                        ACT_ADD:
                        begin
                            adj_raddr = in_data.vertex_a;
                            if (NW'(in_data.vertex_a) >= n_eff ||
                                NW'(in_data.vertex_b) >= n_eff)
                            begin
                                od_next.status = 1'b1;
                                ov_next = 1'b1;
                                state_next = S_OUT;
                            end
                            else
                                state_next = S_EA;
                        end
                        ACT_FIND:
                        begin
                            visited_next = '0;
                            cut_next = '0;
                            time_next = '0;
                            r_next = '0;
                            sp_next = '0;
                            state_next = S_ROOT;
                        end
                        ACT_CLEAR:
                        begin
                            row_valid_next = '0;
                            ov_next = 1'b1;
                            state_next = S_OUT;
                        end
                        default:
                        begin
                            ov_next = 1'b1;
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_EA:
            begin
                adj_we = 1'b1;
                adj_waddr = a_reg;
                adj_wdata = rd_row | (MAX_VERTICES'(1) << b_reg);
                row_valid_next[a_reg] = 1'b1;
                adj_raddr = b_reg;
                state_next = S_EB;
            end
            S_EB:
            begin
                adj_we = 1'b1;
                adj_waddr = b_reg;
                adj_wdata = rd_row | (MAX_VERTICES'(1) << a_reg);
                row_valid_next[b_reg] = 1'b1;
                ov_next = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    ov_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            S_ROOT:
            begin
                adj_raddr = r_reg[VW-1:0];
                if (r_reg >= n_eff)
                begin
                    od_next.cut_mask = cut_reg;
                    ov_next = 1'b1;
                    state_next = S_OUT;
                end
                else if (visited_reg[r_reg[VW-1:0]])
                    r_next = r_reg + NW'(1);
                else
                begin
                    visited_next[r_reg[VW-1:0]] = 1'b1;
                    time_next = t_inc;
                    low_u_next = t_inc;
                    disc_we = 1'b1;
                    disc_waddr = r_reg[VW-1:0];
                    par_we = 1'b1;
                    par_waddr = r_reg[VW-1:0];
                    par_wdata = r_reg[VW-1:0];
                    u_next = r_reg[VW-1:0];
                    par_u_next = r_reg[VW-1:0];
                    rc_next = '0;
                    sp_next = NW'(1);
                    nxt_next = '0;
                    state_next = S_ROW;
                end
            end
            S_ROW:
            begin
                row_next = rd_row;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                adj_raddr = nv;
                if (nxt_reg < n_eff)
                begin
                    nxt_next = nxt_reg + NW'(1);
                    if (row_reg[nv])
                    begin
                        if (!visited_reg[nv])
                        begin
                            if (sp_reg == NW'(1))
                                rc_next = rc_reg + CW'(1);
                            stk_we = 1'b1;
                            stk_wdata = {nxt_reg + NW'(1), u_reg};
                            low_we = 1'b1;
                            visited_next[nv] = 1'b1;
                            time_next = t_inc;
                            low_u_next = t_inc;
                            disc_we = 1'b1;
                            disc_waddr = nv;
                            par_we = 1'b1;
                            par_waddr = nv;
                            par_u_next = u_reg;
                            u_next = nv;
                            sp_next = sp_reg + NW'(1);
                            nxt_next = '0;
                            state_next = S_ROW;
                        end
                        else if (nv != par_u_reg)
                            state_next = S_DISC;
                    end
                end
                else
                begin
                    sp_next = sp_m1;
                    if (sp_reg > NW'(1))
                    begin
                        low_c_next = low_u_reg;
                        state_next = S_POP1;
                    end
                    else
                    begin
                        if (rc_reg > CW'(1))
                            cut_next[u_reg] = 1'b1;
                        r_next = r_reg + NW'(1);
                        state_next = S_ROOT;
                    end
                end
            end
            S_DISC:
            begin
                if (disc_rdata_reg < low_u_reg)
                    low_u_next = disc_rdata_reg;
                state_next = S_SCAN;
            end
            S_POP1:
            begin
                adj_raddr = pp;
                disc_raddr = pp;
                stk_raddr = sp_m1[VW-1:0];
                state_next = S_POP2;
            end
            S_POP2:
            begin
                if (sp_reg > NW'(1) && low_c_reg >= disc_rdata_reg)
                    cut_next[pp] = 1'b1;
                u_next = pp;
                nxt_next = stk_rdata_reg[VW+NW-1:VW];
                low_u_next = lp;
                par_u_next = par_rdata_reg;
                row_next = rd_row;
                state_next = S_SCAN;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adj_we)
            adj_mem[adj_waddr] <= adj_wdata;
        adj_rdata_reg <= adj_mem[adj_raddr];
        if (disc_we)
            disc_mem[disc_waddr] <= disc_wdata;
        disc_rdata_reg <= disc_mem[disc_raddr];
        if (low_we)
            low_mem[low_waddr] <= low_wdata;
        low_rdata_reg <= low_mem[low_raddr];
        if (par_we)
            par_mem[par_waddr] <= par_wdata;
        par_rdata_reg <= par_mem[par_raddr];
        if (stk_we)
            stack_mem[stk_waddr] <= stk_wdata;
        stk_rdata_reg <= stack_mem[stk_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= CW'(MAX_VERTICES);
            row_valid_reg  <= '0;
            adj_rvalid_reg <= 1'b0;
            ov_reg         <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            row_valid_reg  <= row_valid_next;
            adj_rvalid_reg <= row_valid_reg[adj_raddr];
            ov_reg         <= ov_next;
            if (cfg_valid && cfg_ready)
                count_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        visited_reg <= visited_next;
        cut_reg     <= cut_next;
        row_reg     <= row_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        u_reg       <= u_next;
        par_u_reg   <= par_u_next;
        nxt_reg     <= nxt_next;
        r_reg       <= r_next;
        sp_reg      <= sp_next;
        time_reg    <= time_next;
        low_u_reg   <= low_u_next;
        low_c_reg   <= low_c_next;
        rc_reg      <= rc_next;
        od_reg      <= od_next;
    end

endmodule

// ----- dv/articulation_point_finder_tb.sv -----
`timescale 1ns / 100ps
// Testbench for articulation_point_finder: directed table then random graph traffic,
// each result checked against its table value or a behavioral cut-vertex predictor. Depends on apf_pkg.
module articulation_point_finder_tb;
    import apf_pkg::*;

    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 3000000;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    apf_in_t  in_data;
    logic     out_valid;
    logic     out_stall;
    apf_out_t out_data;
    logic     cfg_valid;
    logic     cfg_ready;
    logic [CW-1:0] cfg_data;

    articulation_point_finder DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    logic [63:0] graph_rows [64];
    logic [6:0]  vcount_reg;
    apf_out_t    expected_words [$];
    int          mismatch_count;
    int          cycle_count;
    bit          quiet_tail;
    bit          hold_off_req;

    typedef struct {
        apf_in_t     word;
        bit          has_gold;
        logic        gold_status;
        logic [63:0] gold_mask;
    } table_row_t;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int live_count();
        if (vcount_reg < 7'd1)
            return 1;
        if (vcount_reg > 7'd64)
            return 64;
        return int'(vcount_reg);
    endfunction

    function automatic logic [63:0] find_cut_set();
        int n;
        int sp;
        int u;
        int v;
        int p;
        int nxt;
        int root_kids;
        logic [63:0] seen;
        logic [63:0] cuts;
        int disc [64];
        int lowv [64];
        int par [64];
        int stk_v [64];
        int stk_n [64];
        int clock_t;
        n = live_count();
        seen = '0;
        cuts = '0;
        clock_t = 0;
        sp = 0;
        for (int r = 0; r < n; r++)
        begin
            if (seen[r])
                continue;
            root_kids = 0;
            seen[r] = 1'b1;
            clock_t++;
            disc[r] = clock_t;
            lowv[r] = clock_t;
            par[r] = r;
            stk_v[0] = r;
            stk_n[0] = 0;
            sp = 1;
            while (sp > 0)
            begin
                u = stk_v[sp-1];
                nxt = stk_n[sp-1];
                while (nxt < n && !graph_rows[u][nxt])
                    nxt++;
                if (nxt < n)
                begin
                    v = nxt;
                    stk_n[sp-1] = nxt + 1;
                    if (!seen[v])
                    begin
                        if (sp == 1)
                            root_kids++;
                        seen[v] = 1'b1;
                        clock_t++;
                        disc[v] = clock_t;
                        lowv[v] = clock_t;
                        par[v] = u;
                        stk_v[sp] = v;
                        stk_n[sp] = 0;
                        sp++;
                    end
                    else if (v != par[u] && disc[v] < lowv[u])
                        lowv[u] = disc[v];
                end
                else
                begin
                    sp--;
                    if (sp > 0)
                    begin
                        p = stk_v[sp-1];
                        if (lowv[u] < lowv[p])
                            lowv[p] = lowv[u];
                        if (sp > 1 && lowv[u] >= disc[p])
                            cuts[p] = 1'b1;
                    end
                    else if (root_kids > 1)
                        cuts[u] = 1'b1;
                end
            end
        end
        return cuts;
    endfunction

    function automatic apf_out_t predict_word(apf_in_t w);
        apf_out_t r;
        int n;
        n = live_count();
        r = '0;
        case (w.action)
            ACT_ADD:
                if (w.vertex_a >= n || w.vertex_b >= n)
                    r.status = 1'b1;
                else
                begin
                    graph_rows[w.vertex_a][w.vertex_b] = 1'b1;
                    graph_rows[w.vertex_b][w.vertex_a] = 1'b1;
                end
            ACT_FIND:
                r.cut_mask = find_cut_set();
            ACT_CLEAR:
                for (int i = 0; i < 64; i++)
                    graph_rows[i] = '0;
            default:
                r = '0;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic send_word(apf_in_t w, apf_out_t gold, bit has_gold);
        apf_out_t p;
        int gap;
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 13);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        p = predict_word(w);
        if (has_gold && p.status != gold.status)
            report_mismatch("table status", 64'(p.status), 64'(gold.status));
        if (has_gold && p.cut_mask != gold.cut_mask)
            report_mismatch("table cut_mask", p.cut_mask, gold.cut_mask);
        expected_words = {expected_words, (has_gold ? gold : p)};
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_count(logic [6:0] val);
        drain();
        repeat (9000) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        vcount_reg = val;
    endtask

    function automatic apf_in_t mk(logic [1:0] a, int x, int y);
        apf_in_t w;
        w.action = a;
        w.vertex_a = x[VW-1:0];
        w.vertex_b = y[VW-1:0];
        return w;
    endfunction

    task automatic run_random(int count, int nmax);
        apf_in_t w;
        int k;
        for (int i = 0; i < count; i++)
        begin
            k = $urandom_range(0, 19);
            if (k < 14)
                w = mk(ACT_ADD, $urandom_range(0, nmax), $urandom_range(0, nmax));
            else if (k < 18)
                w = mk(ACT_FIND, $urandom, $urandom);
            else if (k == 18)
                w = mk(ACT_CLEAR, $urandom, $urandom);
            else
                w = mk(ACT_NONE, $urandom, $urandom);
            send_word(w, '0, 0);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
            begin
                $display("unexpected word %h at %0t", out_data, $realtime);
                mismatch_count++;
            end
            else
            begin
                if (out_data.status !== expected_words[0].status)
                    report_mismatch("status", 64'(out_data.status),
                                    64'(expected_words[0].status));
                if (out_data.cut_mask !== expected_words[0].cut_mask)
                    report_mismatch("cut_mask", out_data.cut_mask,
                                    expected_words[0].cut_mask);
                void'(expected_words.pop_front());
            end
        end
    end

    initial
    begin
        int gap;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                out_stall <= 1'b0;
                hold_off_req = 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 13);
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        table_row_t rows [14];
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        mismatch_count = 0;
        cycle_count = 0;
        quiet_tail = 1'b0;
        hold_off_req = 1'b0;
        vcount_reg = 7'd64;
        for (int i = 0; i < 64; i++)
            graph_rows[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows[0]  = '{mk(ACT_FIND, 0, 0), 1, 1'b0, 64'h0};
        rows[1]  = '{mk(ACT_ADD, 0, 63), 1, 1'b0, 64'h0};
        rows[2]  = '{mk(ACT_ADD, 63, 62), 1, 1'b0, 64'h0};
        rows[3]  = '{mk(ACT_FIND, 63, 63), 1, 1'b0, 64'h8000_0000_0000_0000};
        rows[4]  = '{mk(ACT_ADD, 5, 5), 1, 1'b0, 64'h0};
        rows[5]  = '{mk(ACT_ADD, 0, 63), 1, 1'b0, 64'h0};
        rows[6]  = '{mk(ACT_NONE, 63, 63), 1, 1'b0, 64'h0};
        rows[7]  = '{mk(ACT_ADD, 1, 2), 0, 1'b0, 64'h0};
        rows[8]  = '{mk(ACT_ADD, 2, 0), 0, 1'b0, 64'h0};
        rows[9]  = '{mk(ACT_ADD, 2, 3), 0, 1'b0, 64'h0};
        rows[10] = '{mk(ACT_ADD, 3, 1), 0, 1'b0, 64'h0};
        rows[11] = '{mk(ACT_FIND, 0, 0), 0, 1'b0, 64'h0};
        rows[12] = '{mk(ACT_CLEAR, 42, 21), 1, 1'b0, 64'h0};
        rows[13] = '{mk(ACT_FIND, 21, 42), 1, 1'b0, 64'h0};
        foreach (rows[i])
            send_word(rows[i].word, '{rows[i].gold_status, rows[i].gold_mask},
                      rows[i].has_gold);

        write_count(7'd1);
        send_word(mk(ACT_ADD, 0, 1), '{1'b1, 64'h0}, 1);
        send_word(mk(ACT_ADD, 0, 0), '{1'b0, 64'h0}, 1);
        send_word(mk(ACT_FIND, 0, 0), '{1'b0, 64'h0}, 1);
        write_count(7'd0);
        send_word(mk(ACT_FIND, 0, 0), '{1'b0, 64'h0}, 1);
        write_count(7'd127);
        send_word(mk(ACT_ADD, 63, 0), '{1'b0, 64'h0}, 1);

        write_count(7'd8);
        hold_off_req = 1'b1;
        run_random(40, 9);
        write_count(7'd16);
        run_random(30, 17);
        write_count(7'd64);
        run_random(30, 63);
        write_count(7'd5);
        quiet_tail = 1'b1;
        run_random(20, 6);
        drain();
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// ----- files.f -----
sv/apf_pkg.sv
sv/articulation_point_finder.sv
dv/articulation_point_finder_tb.sv
